### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define PFE_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset, for reset behavior.
`define PFE_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/pfe_pkg.sv
package pfe_pkg;

   // Field widths of the stream words.
   localparam int SYMBOL_W   = 8;
   localparam int TOTAL_W    = 32;
   localparam int DEPTH_W    = 5;
   localparam int STATUS_W   = 3;
   localparam int RSP_DATA_W = TOTAL_W + DEPTH_W + STATUS_W;

   // Character codes.
   localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'h39;
   localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [SYMBOL_W-1:0] CH_SPACE = 8'h20;

   // Status codes.
   localparam logic [STATUS_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ERR_UNDERFLOW = 3'd1;
   localparam logic [STATUS_W-1:0] ERR_BADCHAR   = 3'd2;
   localparam logic [STATUS_W-1:0] ERR_DIVZERO   = 3'd3;
   localparam logic [STATUS_W-1:0] ERR_OVERFLOW  = 3'd4;

   // Per-cell shift control: take the neighbor above or the one below.
   typedef struct packed {
      logic take_above;
      logic take_below;
   } cell_ctl_type;

   // Request to the iterative multiply/divide unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } arith_req_type;

endpackage

### design/pfe_cell.sv
module pfe_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  pfe_pkg::cell_ctl_type    ctl,
   input  logic [VALUE_WIDTH-1:0]   from_above,
   input  logic [VALUE_WIDTH-1:0]   from_below,
   output logic [VALUE_WIDTH-1:0]   value
);

   logic [VALUE_WIDTH-1:0] value_ff;

   // One stack entry: shifts down on a push, up on a pop.
   always_ff @(posedge clock) begin
      if (ctl.take_above) begin
         value_ff <= from_above;
      end else if (ctl.take_below) begin
         value_ff <= from_below;
      end
   end

   assign value = value_ff;

endmodule

### design/pfe_arith.sv
module pfe_arith #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pfe_pkg::arith_req_type   req,
   input  logic [VALUE_WIDTH-1:0]   operand_a,
   input  logic [VALUE_WIDTH-1:0]   operand_b,
   output logic                     done,
   output logic [VALUE_WIDTH-1:0]   result
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   div_ff, div_in;
   logic                   neg_ff, neg_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] x_ff, x_in;
   logic [VALUE_WIDTH-1:0] y_ff, y_in;
   logic [VALUE_WIDTH-1:0] r_ff, r_in;
   logic [VALUE_WIDTH:0]   shifted;
   logic [VALUE_WIDTH:0]   diff;
   logic [VALUE_WIDTH-1:0] mag_a;
   logic [VALUE_WIDTH-1:0] mag_b;

   // Magnitudes for the signed divide.
   assign mag_a = operand_a[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - operand_a) : operand_a;
   assign mag_b = operand_b[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - operand_b) : operand_b;

   // Restoring divide step: trial subtract of the divisor.
   assign shifted = {r_ff, x_ff[VALUE_WIDTH-1]};
   assign diff    = shifted - {1'b0, y_ff};

   // One bit per cycle: shift-add multiply or restoring divide.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      if (req.start) begin
         busy_in = 1'b1;
         div_in  = req.is_div;
         cnt_in  = CNT_W'(VALUE_WIDTH);
         r_in    = '0;
         if (req.is_div) begin
            x_in   = mag_a;
            y_in   = mag_b;
            neg_in = operand_a[VALUE_WIDTH-1] ^ operand_b[VALUE_WIDTH-1];
         end else begin
            x_in   = operand_b;
            y_in   = operand_a;
            neg_in = 1'b0;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (div_ff) begin
            if (!diff[VALUE_WIDTH]) begin
               r_in = diff[VALUE_WIDTH-1:0];
               x_in = {x_ff[VALUE_WIDTH-2:0], 1'b1};
            end else begin
               r_in = shifted[VALUE_WIDTH-1:0];
               x_in = {x_ff[VALUE_WIDTH-2:0], 1'b0};
            end
         end else begin
            if (x_ff[0]) begin
               r_in = r_ff + y_ff;
            end
            y_in = {y_ff[VALUE_WIDTH-2:0], 1'b0};
            x_in = {1'b0, x_ff[VALUE_WIDTH-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      r_ff   <= r_in;
   end

   // Quotient takes the sign back; the product is the low bits as they stand.
   assign done   = done_ff;
   assign result = div_ff ? (neg_ff ? (VALUE_WIDTH'(0) - x_ff) : x_ff) : r_ff;

endmodule

### design/postfix_expression_evaluator_unit.sv
// Channel | Direction | Handshake             | Payload
// req     | in        | req_tvalid/req_tready | tdata[7:0] symbol, tlast end_of_expression
// rsp     | out       | rsp_tvalid/rsp_tready | tdata total, depth_left, status
//
// A digit, a space, + or -, or an error character is taken in the idle state with no wait.
// A * or / waits in the arith state for the one-bit-per-cycle
// shift-add / restoring divide unit, which holds off the input until it is done.
// For the word marked last, the flush state places the result in the output register,
// and it waits only while an earlier result is still not taken.
// Reset is synchronous and active high; the stack needs no clearing pass after it.
// A stalled result register holds its word; later words still enter up to the next word
// marked last, which then waits in the flush state and holds off the input.

`include "assert_macros.svh"

module postfix_expression_evaluator_unit #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pfe_pkg::SYMBOL_W-1:0]      req_tdata,  // [7:0] symbol
   input  logic                              req_tlast,  // end_of_expression
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pfe_pkg::RSP_DATA_W-1:0]    rsp_tdata   // [31:0] total, [36:32] depth_left,
                                                         // [39:37] status
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ARITH = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [1:0]                        state_ff, state_in;
   logic [SP_W-1:0]                   sp_ff, sp_in;
   logic [pfe_pkg::STATUS_W-1:0]      err_ff, err_in;
   logic                              prev_unrec_ff, prev_unrec_in;
   logic                              last_ff, last_in;
   logic [VALUE_WIDTH-1:0]            bottom_ff, bottom_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pfe_pkg::TOTAL_W-1:0]       rsp_total_ff, rsp_total_in;
   logic [pfe_pkg::DEPTH_W-1:0]       rsp_depth_ff, rsp_depth_in;
   logic [pfe_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   logic [VALUE_WIDTH-1:0]            cell_val [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0]            cell_above [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0]            cell_below [STACK_DEPTH];
   pfe_pkg::cell_ctl_type             cell_ctl [STACK_DEPTH];

   pfe_pkg::arith_req_type            arith_req;
   logic                              arith_done;
   logic [VALUE_WIDTH-1:0]            arith_result;

   logic [pfe_pkg::SYMBOL_W-1:0]      symbol;
   logic                              is_digit;
   logic                              is_addsub;
   logic                              is_op;
   logic                              recognized;
   logic [VALUE_WIDTH-1:0]            digit_val;
   logic [VALUE_WIDTH-1:0]            addsub_val;
   logic                              do_push;
   logic                              do_combine;
   logic [VALUE_WIDTH-1:0]            combine_val;
   logic                              flush_go;

   // Character decode.
   assign symbol     = req_tdata;
   assign is_digit   = (symbol >= pfe_pkg::CH_ZERO) && (symbol <= pfe_pkg::CH_NINE);
   assign is_addsub  = (symbol == pfe_pkg::CH_PLUS) || (symbol == pfe_pkg::CH_MINUS);
   assign is_op      = is_addsub || (symbol == pfe_pkg::CH_STAR)
                       || (symbol == pfe_pkg::CH_SLASH);
   assign recognized = is_digit || is_op || (symbol == pfe_pkg::CH_SPACE);
   assign digit_val  = VALUE_WIDTH'(symbol - pfe_pkg::CH_ZERO);

   // Add and subtract finish in the same cycle; top of stack is cell 0.
   assign addsub_val = (symbol == pfe_pkg::CH_PLUS) ? (cell_val[1] + cell_val[0])
                                                    : (cell_val[1] - cell_val[0]);

   assign flush_go = (state_ff == S_FLUSH) && (!rsp_valid_ff || rsp_tready);

   // Sequencer: decode, stack moves, errors and result formation.
   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      err_in        = err_ff;
      prev_unrec_in = prev_unrec_ff;
      last_in       = last_ff;
      bottom_in     = bottom_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_total_in  = rsp_total_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      arith_req     = '0;
      do_push       = 1'b0;
      do_combine    = 1'b0;
      combine_val   = addsub_val;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               last_in = req_tlast;
               if (err_ff == pfe_pkg::ERR_NONE) begin
                  prev_unrec_in = !recognized;
                  if (recognized && prev_unrec_ff) begin
                     err_in = pfe_pkg::ERR_BADCHAR;
                  end else if (is_digit) begin
                     if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                        err_in = pfe_pkg::ERR_OVERFLOW;
                     end else begin
                        do_push = 1'b1;
                     end
                  end else if (is_op) begin
                     if (sp_ff < SP_W'(2)) begin
                        err_in = pfe_pkg::ERR_UNDERFLOW;
                     end else if (is_addsub) begin
                        do_combine = 1'b1;
                     end else if ((symbol == pfe_pkg::CH_SLASH) && (cell_val[0] == '0)) begin
                        err_in = pfe_pkg::ERR_DIVZERO;
                     end else begin
                        arith_req.start  = 1'b1;
                        arith_req.is_div = (symbol == pfe_pkg::CH_SLASH);
                     end
                  end
               end
               if (arith_req.start) begin
                  state_in = S_ARITH;
               end else if (req_tlast) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_ARITH: begin
            if (arith_done) begin
               do_combine  = 1'b1;
               combine_val = arith_result;
               state_in    = last_ff ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (flush_go) begin
               rsp_valid_in  = 1'b1;
               rsp_depth_in  = pfe_pkg::DEPTH_W'(sp_ff);
               rsp_status_in = err_ff;
               if (sp_ff != '0) begin
                  rsp_total_in = pfe_pkg::TOTAL_W'($signed(bottom_ff));
               end else begin
                  rsp_total_in = '0;
                  if (err_ff == pfe_pkg::ERR_NONE) begin
                     rsp_status_in = pfe_pkg::ERR_UNDERFLOW;
                  end
               end
               sp_in         = '0;
               err_in        = pfe_pkg::ERR_NONE;
               prev_unrec_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Pointer and bottom-entry tracking for pushes and pops.
      if (do_push) begin
         sp_in = sp_ff + SP_W'(1);
         if (sp_ff == '0) begin
            bottom_in = digit_val;
         end
      end else if (do_combine) begin
         sp_in = sp_ff - SP_W'(1);
         if (sp_ff == SP_W'(2)) begin
            bottom_in = combine_val;
         end
      end
   end

   // Neighbor wiring and shift control for the row of stack cells.
   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         cell_above[i] = (i == 0) ? (do_push ? digit_val : combine_val)
                                  : cell_val[(i == 0) ? 0 : i - 1];
         cell_below[i] = (i == STACK_DEPTH - 1) ? '0
                                                : cell_val[(i == STACK_DEPTH - 1) ? i : i + 1];
         cell_ctl[i].take_above = do_push || (do_combine && (i == 0));
         cell_ctl[i].take_below = do_combine && (i != 0);
      end
   end

   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
      pfe_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .from_above (cell_above[g]),
         .from_below (cell_below[g]),
         .value      (cell_val[g])
      );
   end

   pfe_arith #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_arith (
      .clock     (clock),
      .reset     (reset),
      .req       (arith_req),
      .operand_a (cell_val[1]),
      .operand_b (cell_val[0]),
      .done      (arith_done),
      .result    (arith_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sp_ff         <= '0;
         err_ff        <= pfe_pkg::ERR_NONE;
         prev_unrec_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sp_ff         <= sp_in;
         err_ff        <= err_in;
         prev_unrec_ff <= prev_unrec_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      last_ff       <= last_in;
      bottom_ff     <= bottom_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_status_ff, rsp_depth_ff, rsp_total_ff};

   // Checks on the sequencer and stack bookkeeping.
   `PFE_ASSERT_RST(a_reset_clears, clock,
      reset |=> (sp_ff == '0 && state_ff == S_IDLE && !rsp_valid_ff),
      "reset did not clear the sequencer")
   `PFE_ASSERT_CLK(a_sp_bound, clock, reset, sp_ff <= SP_W'(STACK_DEPTH),
      "stack pointer beyond depth")
   `PFE_ASSERT_CLK(a_done_in_arith, clock, reset, arith_done |-> state_ff == S_ARITH,
      "arith result outside wait state")
   `PFE_ASSERT_CLK(a_err_sticky, clock, reset,
      (err_ff != pfe_pkg::ERR_NONE && state_ff != S_FLUSH) |=> err_ff == $past(err_ff),
      "error code changed before result")
   `PFE_ASSERT_CLK(a_empty_not_ok, clock, reset,
      (flush_go && sp_ff == '0) |=> rsp_status_ff != pfe_pkg::ERR_NONE,
      "empty stack reported as ok")

endmodule

### test/postfix_expression_evaluator_unit_tb.sv
module postfix_expression_evaluator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH = 16;
   localparam int ITEM_TARGET = 1450;
   localparam int HOLD_OFF_CYCLES = 300;

   // One result word as it appears on rsp_tdata, total in the lowest bits.
   typedef struct packed {
      logic [pfe_pkg::STATUS_W-1:0] status;
      logic [pfe_pkg::DEPTH_W-1:0]  depth_left;
      logic [pfe_pkg::TOTAL_W-1:0]  total;
   } result_word_type;

   // Evaluates the character stream on its own stack and checks the results.
   class rpn_scoreboard;
      logic [pfe_pkg::TOTAL_W-1:0]  stack_mem[STACK_DEPTH];
      int unsigned                  stack_top;
      logic [pfe_pkg::STATUS_W-1:0] sticky_err;
      bit                           prev_unrecognized;
      result_word_type              expected_q[$];
      int                           error_count;

      function void clear_state();
         foreach (stack_mem[i]) stack_mem[i] = '0;
         stack_top = 0;
         sticky_err = pfe_pkg::ERR_NONE;
         prev_unrecognized = 1'b0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Pops two operands and folds them into the new top of the stack.
      function void apply_operator(logic [pfe_pkg::SYMBOL_W-1:0] sym);
         logic [pfe_pkg::TOTAL_W-1:0] lhs, rhs, res;
         longint quotient;
         if (stack_top < 2) begin
            sticky_err = pfe_pkg::ERR_UNDERFLOW;
            return;
         end
         lhs = stack_mem[stack_top-2];
         rhs = stack_mem[stack_top-1];
         case (sym)
            pfe_pkg::CH_PLUS:  res = lhs + rhs;
            pfe_pkg::CH_MINUS: res = lhs - rhs;
            pfe_pkg::CH_STAR:  res = lhs * rhs;
            default: begin
               if (rhs == '0) begin
                  sticky_err = pfe_pkg::ERR_DIVZERO;
                  return;
               end
               // 64-bit signed division truncates toward zero and cannot overflow.
               quotient = longint'($signed(lhs)) / longint'($signed(rhs));
               res = quotient[pfe_pkg::TOTAL_W-1:0];
            end
         endcase
         stack_top--;
         stack_mem[stack_top-1] = res;
      endfunction

      // Called for every word accepted on the request side.
      function void note_symbol(logic [pfe_pkg::SYMBOL_W-1:0] sym, logic last);
         bit is_digit, is_oper, known;
         result_word_type want;
         is_digit = (sym >= pfe_pkg::CH_ZERO) && (sym <= pfe_pkg::CH_NINE);
         is_oper = (sym == pfe_pkg::CH_PLUS) || (sym == pfe_pkg::CH_MINUS)
            || (sym == pfe_pkg::CH_STAR) || (sym == pfe_pkg::CH_SLASH);
         known = is_digit || is_oper || (sym == pfe_pkg::CH_SPACE);
         if (sticky_err == pfe_pkg::ERR_NONE) begin
            if (known && prev_unrecognized) begin
               sticky_err = pfe_pkg::ERR_BADCHAR;
            end else if (is_digit) begin
               if (stack_top >= STACK_DEPTH) begin
                  sticky_err = pfe_pkg::ERR_OVERFLOW;
               end else begin
                  stack_mem[stack_top] = pfe_pkg::TOTAL_W'(sym - pfe_pkg::CH_ZERO);
                  stack_top++;
               end
            end else if (is_oper) begin
               apply_operator(sym);
            end
            prev_unrecognized = !known;
         end
         if (!last) return;
         want.total = (stack_top > 0) ? stack_mem[0] : '0;
         want.depth_left = pfe_pkg::DEPTH_W'(stack_top);
         want.status = sticky_err;
         if (stack_top == 0 && sticky_err == pfe_pkg::ERR_NONE) begin
            want.status = pfe_pkg::ERR_UNDERFLOW;
         end
         expected_q.push_back(want);
         clear_state();
      endfunction

      task report(string msg);
         error_count++;
         $display("%0t ns: mismatch: %s", $realtime, msg);
      endtask

      // Called for every word accepted on the response side.
      task check_word(logic [pfe_pkg::RSP_DATA_W-1:0] data);
         result_word_type got, want;
         got = data;
         if (expected_q.size() == 0) begin
            report($sformatf("result word %h with none expected", data));
            return;
         end
         want = expected_q.pop_front();
         if (got.total !== want.total)
            report($sformatf("total %0d, expected %0d", $signed(got.total),
               $signed(want.total)));
         if (got.depth_left !== want.depth_left)
            report($sformatf("depth_left %0d, expected %0d", got.depth_left,
               want.depth_left));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
      endtask
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [pfe_pkg::SYMBOL_W-1:0]     req_tdata = '0;  // [7:0] symbol
   logic                             req_tlast = 1'b0;  // end_of_expression
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [pfe_pkg::RSP_DATA_W-1:0]   rsp_tdata;  // [31:0] total, [36:32] depth_left,
                                                 // [39:37] status

   rpn_scoreboard                    sb;
   logic [pfe_pkg::SYMBOL_W-1:0]     expr_q[$];
   int                               items_sent;
   int                               req_idle_max = 12;
   int                               rsp_idle_max = 12;
   bit                               hold_off_request;
   bit                               pressure_done;

   postfix_expression_evaluator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offers one word after a random gap and holds it until it is taken.
   task automatic send_word(logic [pfe_pkg::SYMBOL_W-1:0] sym, logic last);
      int gap;
      gap = (req_idle_max == 0) ? 0 : $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= sym;
      req_tlast <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_symbol(sym, last);
      items_sent++;
   endtask

   // Sends the queued expression, marking its final character as last.
   task automatic send_expression();
      foreach (expr_q[i]) send_word(expr_q[i], i == expr_q.size() - 1);
      expr_q.delete();
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic void load_text(string s);
      for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
   endfunction

   function automatic logic [pfe_pkg::SYMBOL_W-1:0] pick_operator();
      case ($urandom_range(0, 3))
         0: return pfe_pkg::CH_PLUS;
         1: return pfe_pkg::CH_MINUS;
         2: return pfe_pkg::CH_STAR;
         default: return pfe_pkg::CH_SLASH;
      endcase
   endfunction

   function automatic logic [pfe_pkg::SYMBOL_W-1:0] pick_digit();
      return pfe_pkg::CH_ZERO + pfe_pkg::SYMBOL_W'($urandom_range(0, 9));
   endfunction

   function automatic logic [pfe_pkg::SYMBOL_W-1:0] pick_recognized();
      case ($urandom_range(0, 2))
         0: return pick_digit();
         1: return pick_operator();
         default: return pfe_pkg::CH_SPACE;
      endcase
   endfunction

   // Random valid postfix expression, sometimes leaving extra values on the stack.
   function automatic void add_wellformed();
      int n_digits, pushed, depth_now;
      bit leave_extra;
      n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(9, STACK_DEPTH)
         : $urandom_range(1, 8);
      leave_extra = ($urandom_range(0, 7) == 0);
      pushed = 0;
      depth_now = 0;
      while (pushed < n_digits || (depth_now > 1 && !leave_extra)) begin
         if ($urandom_range(0, 5) == 0) expr_q.push_back(pfe_pkg::CH_SPACE);
         if (depth_now >= 2 && (pushed == n_digits || $urandom_range(0, 1) == 1)) begin
            expr_q.push_back(pick_operator());
            depth_now--;
         end else begin
            expr_q.push_back(pick_digit());
            pushed++;
            depth_now++;
         end
      end
   endfunction

   // Response side: takes words after random stalls, with one long hold-off on request.
   initial begin
      int gap;
      wait (!reset);
      forever begin
         gap = (rsp_idle_max == 0) ? 0 : $urandom_range(0, rsp_idle_max);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            gap = HOLD_OFF_CYCLES;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_word(rsp_tdata);
      end
   end

   // Stimulus and end of run.
   initial begin
      int kind, pos;
      sb = new();
      sb.clear_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: every operator, the symbol extremes and the special cases.
      load_text("34+2-5*7/");
      send_expression();
      load_text("+");
      send_expression();
      load_text("50/");
      send_expression();
      load_text("1x2");
      send_expression();
      load_text("12");
      expr_q.push_back(8'hFF);
      send_expression();
      load_text("7");
      expr_q.push_back(8'h00);
      send_expression();
      load_text(" ");
      send_expression();

      // Random expressions, mostly well formed.
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 15) == 0) begin
            req_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            rsp_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
         end
         // Fill the block while the response side is held off, then drain it.
         if (!pressure_done && items_sent >= ITEM_TARGET / 2) begin
            pressure_done = 1'b1;
            hold_off_request = 1'b1;
            repeat (40) begin
               expr_q.push_back(pick_digit());
               send_expression();
            end
            req_tvalid <= 1'b0;
            wait_drained();
         end
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            add_wellformed();
         end else if (kind < 78) begin
            // Well-formed expression broken by a stray character.
            add_wellformed();
            pos = $urandom_range(0, expr_q.size());
            if ($urandom_range(0, 1) == 1) begin
               expr_q.insert(pos, pfe_pkg::SYMBOL_W'($urandom_range(0, 255)));
            end else begin
               expr_q.insert(0, pick_operator());
            end
         end else if (kind < 86) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 1) == 1) begin
                  expr_q.push_back(pfe_pkg::SYMBOL_W'($urandom_range(0, 255)));
               end else begin
                  expr_q.push_back(pick_recognized());
               end
            end
         end else if (kind < 92) begin
            // Push past a full stack.
            repeat (STACK_DEPTH + $urandom_range(1, 3)) expr_q.push_back(pick_digit());
            if ($urandom_range(0, 1) == 1) expr_q.push_back(pick_operator());
         end else if (kind < 95) begin
            // Build the most negative value and divide it by minus one.
            load_text("02-");
            repeat (10) load_text("8*");
            load_text("01-/");
            if ($urandom_range(0, 1) == 1) load_text("3+");
         end else begin
            repeat ($urandom_range(1, 3)) expr_q.push_back(pfe_pkg::CH_SPACE);
            if ($urandom_range(0, 1) == 1) expr_q.push_back(pick_operator());
         end
         send_expression();
      end
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (80) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
      if (sb.error_count == 0) begin
         $display("postfix_expression_evaluator_unit_tb: clean");
      end else begin
         $display("postfix_expression_evaluator_unit_tb: errors");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("postfix_expression_evaluator_unit_tb: errors");
      $finish;
   end

endmodule

### postfix_expression_evaluator_unit.f
+incdir+design
design/pfe_pkg.sv
design/pfe_cell.sv
design/pfe_arith.sv
design/postfix_expression_evaluator_unit.sv
test/postfix_expression_evaluator_unit_tb.sv
